// ===== src/mask_single_hole_fill_assert.svh =====
// Assertion macros for the mask hole fill port checker.
`ifndef MASK_SINGLE_HOLE_FILL_ASSERT_SVH
`define MASK_SINGLE_HOLE_FILL_ASSERT_SVH

// Checked every cycle outside reset.
`define MSHF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked in every cycle, reset included.
`define MSHF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/mshf_pkg.sv =====
// Shared constants and types for the mask single hole fill block.
`default_nettype none

package mshf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_DIM    = 3;

   localparam int PIXEL_W     = 8;
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 13;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = HEIGHT_W;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(4096);
   localparam logic [PIXEL_W-1:0]  LABEL_RESET  = '0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_FILL_LABEL   = 2'd2
   } csr_index_type;

   // Per-item control carried from the accept stage to the window stage.
   typedef struct packed {
      logic             emit;
      logic             border;
      logic             last;
      logic [COL_W-1:0] col;
   } slot_ctrl_type;

endpackage

`default_nettype wire

// ===== src/mshf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mshf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/mask_single_hole_fill.sv =====
// Top level of the streaming single-pixel hole fill for 8-bit label masks.
`default_nettype none

// Takes one mask pixel per cycle, when not stalled, in raster order and returns
// the filtered pixel image_width+1 items later: an interior pixel whose up, down,
// left and right neighbors all equal fill_label becomes fill_label, every other
// pixel and all border rows and columns pass unchanged. Sustained rate is one
// item per clock while the output is not stalled; a result is registered in the
// window stage, fed by the registered read of the two line-store RAMs, and then in
// the output register. Nothing comes out for the first image_width+1 items of a
// frame, so send image_width+1 padding items after the last pixel to flush it;
// frame_end marks the final pixel, after which the next item starts a new
// frame. Width and height are clamped to [3, 1024] and [3, 4096]. The line
// stores are not cleared after reset; entries not yet written feed only border
// pixels. Write the registers while the block is idle.
module mask_single_hole_fill
   import mshf_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [PIXEL_W-1:0]      req_mask_pixel,
   input  wire logic                    req_is_padding,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic      [PIXEL_W-1:0]      rsp_out_pixel,
   output logic                         rsp_frame_end,
   input  wire logic                    csr_we,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   // Configuration
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [PIXEL_W-1:0]  label_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         label_ff  <= LABEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
            CSR_FILL_LABEL:   label_ff  <= csr_wdata[PIXEL_W-1:0];
            default: ;
         endcase
      end
   end

   logic [WIDTH_W-1:0]  w_eff;
   logic [HEIGHT_W-1:0] h_eff;

   always_comb begin
      if (width_ff < WIDTH_W'(MIN_DIM)) begin
         w_eff = WIDTH_W'(MIN_DIM);
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff < HEIGHT_W'(MIN_DIM)) begin
         h_eff = HEIGHT_W'(MIN_DIM);
      end else if (height_ff > HEIGHT_W'(MAX_HEIGHT)) begin
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // Accept stage: slot position and per-slot decisions
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               accept;
   logic               col_zero;
   logic [WIDTH_W-1:0] col_next;
   logic [ROW_W-1:0]   orow;
   logic [WIDTH_W-1:0] ocol;
   slot_ctrl_type      slot;

   assign accept = req_valid && !req_stall;

   always_comb begin
      col_zero = (col_ff == '0);
      col_next = WIDTH_W'(col_ff) + WIDTH_W'(1);
      // the output pixel trails the incoming one by one row and one column
      orow = col_zero ? row_ff - ROW_W'(2) : row_ff - ROW_W'(1);
      ocol = col_zero ? w_eff - WIDTH_W'(1) : WIDTH_W'(col_ff) - WIDTH_W'(1);

      slot.emit   = (row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && !col_zero);
      slot.last   = (orow >= h_eff - HEIGHT_W'(1)) && (ocol >= w_eff - WIDTH_W'(1));
      slot.border = (orow == '0) || (orow >= h_eff - HEIGHT_W'(1)) ||
                    (ocol == '0) || (ocol >= w_eff - WIDTH_W'(1));
      slot.col    = col_ff;

      col_in = col_ff;
      row_in = row_ff;
      if (slot.emit && slot.last) begin
         col_in = '0;
         row_in = '0;
      end else if (col_next >= w_eff) begin
         col_in = '0;
         row_in = row_ff + ROW_W'(1);
      end else begin
         col_in = col_next[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Window stage
   logic                s1_valid_ff;
   slot_ctrl_type       s1_ff;
   logic [PIXEL_W-1:0]  s1_pix_ff;
   logic                out_free;
   logic                s1_go;
   logic [PIXEL_W-1:0]  above1;
   logic [PIXEL_W-1:0]  above2;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_ff.emit || out_free);
   assign req_stall = s1_valid_ff && !s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff     <= slot;
         s1_pix_ff <= req_is_padding ? '0 : req_mask_pixel;
      end
   end

   // store a holds the previous row, store b the one before it
   mshf_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_a (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_ff.col),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (above1)
   );

   mshf_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_b (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_ff.col),
      .wr_data (above1),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (above2)
   );

   // Only the taps the cross stencil needs: top right, middle, middle right,
   // bottom right. The incoming column forms the new right edge.
   logic [PIXEL_W-1:0] win_top_ff;
   logic [PIXEL_W-1:0] win_ctr_ff;
   logic [PIXEL_W-1:0] win_mid_ff;
   logic [PIXEL_W-1:0] win_bot_ff;

   always_ff @(posedge clock) begin
      if (s1_go) begin
         win_top_ff <= above2;
         win_ctr_ff <= win_mid_ff;
         win_mid_ff <= above1;
         win_bot_ff <= s1_pix_ff;
      end
   end

   logic               hole;
   logic [PIXEL_W-1:0] filt_pixel;

   always_comb begin
      hole = !s1_ff.border && (win_top_ff == label_ff) && (win_ctr_ff == label_ff) &&
             (above1 == label_ff) && (win_bot_ff == label_ff);
      filt_pixel = hole ? label_ff : win_mid_ff;
   end

   // Result register
   logic               rsp_valid_ff;
   logic [PIXEL_W-1:0] rsp_pixel_ff;
   logic               rsp_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_ff.emit) begin
         rsp_pixel_ff <= filt_pixel;
         rsp_end_ff   <= s1_ff.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;
   assign rsp_frame_end = rsp_end_ff;

endmodule

`default_nettype wire

// ===== src/mshf_checker.sv =====
// Port-level checker for the mask single hole fill block, with its bind.
`default_nettype none

`include "mask_single_hole_fill_assert.svh"

module mshf_checker
   import mshf_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [PIXEL_W-1:0]     rsp_out_pixel,
   input wire logic                   rsp_frame_end
);

   `MSHF_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid && !req_stall, "not idle after reset")
   `MSHF_ASSERT(a_stall_only_when_full, req_stall |-> rsp_valid && rsp_stall, "input stalled while output free")
   `MSHF_ASSERT(a_result_from_item, $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2), "result without an accepted item")
   `MSHF_ASSERT(a_result_holds, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_pixel) && $stable(rsp_frame_end), "stalled result changed")

endmodule

bind mask_single_hole_fill mshf_checker u_mshf_checker (.*);

`default_nettype wire

// ===== sim/hole_fill_checker.sv =====
// Checker that predicts the hole-filled mask stream and compares it with the block's results.
`default_nettype none

module hole_fill_checker
   import mshf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic [PIXEL_W-1:0]     req_mask_pixel,
   input  wire logic                   req_is_padding,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic [PIXEL_W-1:0]     rsp_out_pixel,
   input  wire logic                   rsp_frame_end,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                          fail_count,
   output int                          outstanding,
   output logic                        frame_open
);

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               frame_end;
   } filled_pixel_type;

   filled_pixel_type    expected_pixels [$];

   logic [PIXEL_W-1:0]  two_rows_up [MAX_WIDTH];
   logic [PIXEL_W-1:0]  one_row_up  [MAX_WIDTH];
   logic [PIXEL_W-1:0]  stencil [9];
   int unsigned         slot_col;
   int unsigned         slot_row;
   logic [WIDTH_W-1:0]  width_reg;
   logic [HEIGHT_W-1:0] height_reg;
   logic [PIXEL_W-1:0]  label_reg;
   int                  mismatches = 0;

   // Shift one stream slot into the 3x3 neighborhood and queue the pixel it completes.
   function automatic void advance_hole_fill(input logic [PIXEL_W-1:0] pixel_in);
      int unsigned        w, h, c, r, ci, out_row, out_col;
      logic [PIXEL_W-1:0] up2, up1;
      logic               border, last;
      filled_pixel_type   result;
      int                 k;
      w = width_reg;
      if (w < MIN_DIM) w = MIN_DIM;
      else if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = height_reg;
      if (h < MIN_DIM) h = MIN_DIM;
      else if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      c = slot_col;
      r = slot_row;
      ci = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
      up2 = two_rows_up[ci];
      up1 = one_row_up[ci];
      for (k = 0; k < 3; k++) begin
         stencil[k*3]   = stencil[k*3+1];
         stencil[k*3+1] = stencil[k*3+2];
      end
      stencil[2] = up2;
      stencil[5] = up1;
      stencil[8] = pixel_in;
      two_rows_up[ci] = up1;
      one_row_up[ci]  = pixel_in;
      if (c + 1 >= w) begin
         slot_col = 0;
         slot_row = r + 1;
      end else begin
         slot_col = c + 1;
      end
      // the center lags one row and one column behind the newest slot
      if (r >= 2 || (r == 1 && c >= 1)) begin
         out_row = (c == 0) ? r - 2 : r - 1;
         out_col = (c == 0) ? w - 1 : c - 1;
         border  = out_row == 0 || out_row >= h - 1 || out_col == 0 || out_col >= w - 1;
         last    = out_row >= h - 1 && out_col >= w - 1;
         result.pixel     = stencil[4];
         result.frame_end = last;
         if (!border && stencil[1] == label_reg && stencil[3] == label_reg &&
             stencil[5] == label_reg && stencil[7] == label_reg)
            result.pixel = label_reg;
         expected_pixels.push_back(result);
         if (last) begin
            slot_col = 0;
            slot_row = 0;
         end
      end
   endfunction

   function automatic void check_result();
      filled_pixel_type want;
      if (expected_pixels.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: pixel %02h frame_end %b",
                     rsp_out_pixel, rsp_frame_end);
         return;
      end
      want = expected_pixels.pop_front();
      if (rsp_out_pixel !== want.pixel || rsp_frame_end !== want.frame_end) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected pixel %02h frame_end %b, got pixel %02h frame_end %b",
                     want.pixel, want.frame_end, rsp_out_pixel, rsp_frame_end);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (stencil[k]) stencil[k] = '0;
         foreach (two_rows_up[k]) begin
            two_rows_up[k] = '0;
            one_row_up[k]  = '0;
         end
         slot_col   = 0;
         slot_row   = 0;
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         label_reg  = LABEL_RESET;
         expected_pixels.delete();
      end else begin
         // results leave only after their items are accepted, so check before predicting
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall)
            advance_hole_fill(req_is_padding ? '0 : req_mask_pixel);
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg  = csr_wdata[WIDTH_W-1:0];
               CSR_IMAGE_HEIGHT: height_reg = csr_wdata[HEIGHT_W-1:0];
               CSR_FILL_LABEL:   label_reg  = csr_wdata[PIXEL_W-1:0];
               default: ;
            endcase
         end
      end
      fail_count  <= mismatches;
      outstanding <= expected_pixels.size();
      frame_open  <= (slot_col != 0 || slot_row != 0);
   end

endmodule

`default_nettype wire

// ===== sim/tb_mask_single_hole_fill.sv =====
// Testbench top: streams mask frames into the hole fill block and reports the verdict.
`default_nettype none

module tb_mask_single_hole_fill
   import mshf_pkg::*;
();

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 900;

   typedef enum int {
      PACE_STEADY,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH
   } pace_type;

   typedef enum int {
      FLUSH_EXACT,
      FLUSH_SHORT,
      FLUSH_LONG
   } flush_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_mask_pixel;
   logic                   req_is_padding;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [PIXEL_W-1:0]     rsp_out_pixel;
   logic                   rsp_frame_end;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int                     fail_count;
   int                     outstanding;
   logic                   frame_open;

   int                     idle_pct;
   int                     stall_pct;
   int                     cycle_count = 0;
   int                     sent_items;
   int unsigned            frame_width;
   int unsigned            frame_height;
   logic [PIXEL_W-1:0]     frame_label;

   mask_single_hole_fill DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mask_pixel (req_mask_pixel),
      .req_is_padding (req_is_padding),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_pixel  (rsp_out_pixel),
      .rsp_frame_end  (rsp_frame_end),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   hole_fill_checker fill_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mask_pixel (req_mask_pixel),
      .req_is_padding (req_is_padding),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_pixel  (rsp_out_pixel),
      .rsp_frame_end  (rsp_frame_end),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .frame_open     (frame_open)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic set_pace(input pace_type pace);
      case (pace)
         PACE_SENDER_IDLE: begin
            idle_pct  = 72;
            stall_pct = 0;
         end
         PACE_RECEIVER_STALL: begin
            idle_pct  = 0;
            stall_pct = 72;
         end
         PACE_BOTH: begin
            idle_pct  = 8;
            stall_pct = 8;
         end
         default: begin
            idle_pct  = 0;
            stall_pct = 0;
         end
      endcase
   endtask

   // Offer one item and hold it until the block takes it.
   task automatic send_item(input logic [PIXEL_W-1:0] pixel, input logic padding);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mask_pixel <= pixel;
      req_is_padding <= padding;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   // Pad out any open frame, then wait until every queued result has come back.
   task automatic drain_frame();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_open) begin
         send_item(8'($urandom), 1'b1);
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(input int unsigned w, input int unsigned h,
                               input logic [PIXEL_W-1:0] label);
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_index <= CSR_FILL_LABEL;
      csr_wdata <= CSR_DATA_W'(label);
      @(posedge clock);
      csr_we <= 1'b0;
      frame_width  = (w < MIN_DIM) ? MIN_DIM : (w > MAX_WIDTH) ? MAX_WIDTH : w;
      frame_height = (h < MIN_DIM) ? MIN_DIM : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
      frame_label  = label;
   endtask

   function automatic logic [PIXEL_W-1:0] pick_label();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return 8'($urandom);
      endcase
   endfunction

   // The fill label for density percent of pixels, so that holes and near-holes show up often.
   function automatic logic [PIXEL_W-1:0] mask_value(input int density);
      if ($urandom_range(0, 99) < density) return frame_label;
      if ($urandom_range(0, 1) == 1) return frame_label ^ (8'd1 << $urandom_range(0, 7));
      return 8'($urandom);
   endfunction

   task automatic send_frame(input int density, input flush_mode_type flush);
      int unsigned pixels, flush_len, i;
      pixels = frame_width * frame_height;
      case (flush)
         FLUSH_SHORT: flush_len = $urandom_range(0, frame_width);
         FLUSH_LONG:  flush_len = frame_width + 1 + $urandom_range(1, 2 * frame_width);
         default:     flush_len = frame_width + 1;
      endcase
      for (i = 0; i < pixels; i++)
         send_item(mask_value(density), $urandom_range(0, 99) < 4);
      for (i = 0; i < flush_len; i++) begin
         if ($urandom_range(0, 4) == 0) send_item(8'($urandom), 1'b0);
         else send_item(8'($urandom), 1'b1);
      end
   endtask

   initial begin
      int             frame_no;
      int             random_items;
      int             start_count;
      int             density;
      int             i;
      flush_mode_type flush;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mask_pixel = '0;
      req_is_padding = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_IMAGE_WIDTH;
      csr_wdata      = '0;
      sent_items     = 0;
      idle_pct       = 0;
      stall_pct      = 0;
      frame_width    = MAX_WIDTH;
      frame_height   = MAX_HEIGHT;
      frame_label    = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 3x3 frame with a single hole in the middle; one flush slot carries a stray pixel
      write_config(3, 3, 8'hA5);
      for (i = 0; i < 9; i++) send_item((i == 4) ? 8'h00 : 8'hA5, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(8'h00, 1'b1);
      send_item(8'h5A, 1'b0);
      send_item(8'hFF, 1'b1);
      drain_frame();

      // sizes below the minimum clamp to 3x3; padding neighbors read as label zero
      write_config(0, 0, 8'h00);
      for (i = 0; i < 9; i++) begin
         if (i == 4) send_item(8'h80, 1'b0);
         else if (i % 2 == 1) send_item(8'hFF, 1'b1);
         else send_item(8'hFF, 1'b0);
      end
      for (i = 0; i < 4; i++) send_item(8'hFF, 1'b1);
      drain_frame();

      frame_no     = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS || frame_no < 10) begin
         set_pace(pace_type'((frame_no / 2) % 4));
         start_count = sent_items;
         if (frame_no == 4) begin
            drain_frame();
            write_config(12, 0, pick_label());
            send_frame(75, FLUSH_EXACT);
         end else if (frame_no == 9) begin
            drain_frame();
            write_config(0, 10, pick_label());
            send_frame(75, FLUSH_EXACT);
         end else begin
            if (frame_no == 0 || $urandom_range(0, 3) != 0) begin
               drain_frame();
               write_config(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                        : $urandom_range(3, 12),
                            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                        : $urandom_range(3, 10),
                            pick_label());
            end
            case ($urandom_range(0, 2))
               0:       density = 50;
               1:       density = 75;
               default: density = 92;
            endcase
            case ($urandom_range(0, 9))
               0:       flush = FLUSH_SHORT;
               1:       flush = FLUSH_LONG;
               default: flush = FLUSH_EXACT;
            endcase
            send_frame(density, flush);
         end
         random_items += sent_items - start_count;
         frame_no++;
      end

      set_pace(PACE_STEADY);
      drain_frame();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
